// ----- sv/pdhv_pkg.sv -----
package pdhv_pkg;

    // Default fixed-point formats of the filter datapath.
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int HIST_FRAC_BITS_DEF = 8;

    // Fixed field and register widths.
    localparam int SAMPLE_W   = 16;
    localparam int CENTER_W   = 12;
    localparam int COEF_W     = 20;
    localparam int GAIN_W     = 9;
    localparam int YHIST_W    = 24;
    localparam int DAC_W      = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Decoupling queue between the decoder and the filter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SAMPLE_WIDTH  = 3'd0,
        CFG_STEREO        = 3'd1,
        CFG_FILTER_ENABLE = 3'd2,
        CFG_COEF_B0       = 3'd3,
        CFG_COEF_B1       = 3'd4,
        CFG_COEF_A1       = 3'd5,
        CFG_COEF_A2       = 3'd6,
        CFG_VOLUME_GAIN   = 3'd7
    } cfg_idx_t;

    // Configuration register file contents.
    typedef struct packed {
        logic                     sample_width;
        logic                     stereo;
        logic                     filter_enable;
        logic signed [COEF_W-1:0] coef_b0;
        logic signed [COEF_W-1:0] coef_b1;
        logic signed [COEF_W-1:0] coef_a1;
        logic signed [COEF_W-1:0] coef_a2;
        logic [GAIN_W-1:0]        volume_gain;
    } cfg_t;

    // One decoded frame waiting for the filter.
    typedef struct packed {
        logic signed [CENTER_W-1:0] x;
        logic                       start;
    } qent_t;

endpackage

// ----- sv/pcm_to_dac_highpass_volume.sv -----
// Channel   Ports                          Contents
// input     s_tvalid s_tready s_tdata      tdata[15:0] left_sample, [31:16] right_sample
//           s_tuser                        stream_start
// result    m_tvalid m_tready m_tdata      tdata[11:0] dac_code, [15:12] zero
//           m_tuser                        filter_clipped
// config    cfg_wr_en cfg_addr cfg_wr_data register index and value, no read-back
//
// One frame is accepted per cycle while the queue has room; the biquad feedback update,
// registered on each pop from the queue head, sets that rate. With an empty queue, a frame
// passes the queue, the filter register and the output register before m_tvalid rises.
// Reset is synchronous to aclk, active low; it clears the history and returns the
// configuration to its defaults.
// A four-entry queue decouples the decoder from the filter, so input keeps flowing
// while m_tready is low until the queue fills.
module pcm_to_dac_highpass_volume #(
    parameter int COEF_FRAC_BITS = pdhv_pkg::COEF_FRAC_BITS_DEF,
    parameter int HIST_FRAC_BITS = pdhv_pkg::HIST_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic                              s_tuser,   // stream_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [11:0] dac_code, [15:12] zero
    output logic                              m_tuser,   // filter_clipped
    input  logic                              cfg_wr_en,
    input  logic [pdhv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pdhv_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import pdhv_pkg::*;

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_push;
    qent_t q_in;
    logic  q_pop;
    logic  q_valid;
    qent_t q_head;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_width  <= 1'b1;
            cfg_reg.stereo        <= 1'b0;
            cfg_reg.filter_enable <= 1'b0;
            cfg_reg.coef_b0       <= '0;
            cfg_reg.coef_b1       <= '0;
            cfg_reg.coef_a1       <= '0;
            cfg_reg.coef_a2       <= '0;
            cfg_reg.volume_gain   <= GAIN_W'(165);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SAMPLE_WIDTH:  cfg_reg.sample_width  <= cfg_wr_data[0];
                CFG_STEREO:        cfg_reg.stereo        <= cfg_wr_data[0];
                CFG_FILTER_ENABLE: cfg_reg.filter_enable <= cfg_wr_data[0];
                CFG_COEF_B0:       cfg_reg.coef_b0       <= cfg_wr_data[COEF_W-1:0];
                CFG_COEF_B1:       cfg_reg.coef_b1       <= cfg_wr_data[COEF_W-1:0];
                CFG_COEF_A1:       cfg_reg.coef_a1       <= cfg_wr_data[COEF_W-1:0];
                CFG_COEF_A2:       cfg_reg.coef_a2       <= cfg_wr_data[COEF_W-1:0];
                CFG_VOLUME_GAIN:   cfg_reg.volume_gain   <= cfg_wr_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pdhv_front u_front (
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    pdhv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    pdhv_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .HIST_FRAC_BITS (HIST_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- sv/pdhv_front.sv -----
module pdhv_front (
    input  pdhv_pkg::cfg_t   cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  logic             s_tuser,   // stream_start
    input  logic             q_full,
    output logic             q_push,
    output pdhv_pkg::qent_t  q_data
);
    import pdhv_pkg::*;

    logic [7:0]                 left8;
    logic [7:0]                 right8;
    logic [8:0]                 sum8;
    logic [7:0]                 s8;
    logic signed [SAMPLE_W-1:0] left16;
    logic signed [SAMPLE_W-1:0] right16;
    logic [SAMPLE_W:0]          sum16;
    logic [SAMPLE_W-1:0]        s16;
    logic signed [CENTER_W-1:0] x8;
    logic signed [CENTER_W-1:0] x16;

    // Take a transaction whenever the queue has room.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // 8-bit unsigned samples: average in stereo, then scale by 16 and recenter.
    assign left8  = s_tdata[7:0];
    assign right8 = s_tdata[23:16];
    assign sum8   = {1'b0, left8} + {1'b0, right8};
    assign s8     = cfg.stereo ? sum8[8:1] : left8;
    assign x8     = {~s8[7], s8[6:0], 4'b0000};

    // 16-bit signed samples: floor average in stereo, then floor divide by 16.
    assign left16  = s_tdata[15:0];
    assign right16 = s_tdata[31:16];
    assign sum16   = {left16[SAMPLE_W-1], left16} + {right16[SAMPLE_W-1], right16};
    assign s16     = cfg.stereo ? sum16[SAMPLE_W:1] : left16;
    assign x16     = s16[SAMPLE_W-1:4];

    always_comb begin
        q_data.x     = cfg.sample_width ? x16 : x8;
        q_data.start = s_tuser;
    end

endmodule

// ----- sv/pdhv_queue.sv -----
module pdhv_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pdhv_pkg::qent_t  push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output pdhv_pkg::qent_t  head_data
);
    import pdhv_pkg::*;

    qent_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage has no reset; the count marks which entries hold data.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/pdhv_back.sv -----
module pdhv_back #(
    parameter int COEF_FRAC_BITS = pdhv_pkg::COEF_FRAC_BITS_DEF,
    parameter int HIST_FRAC_BITS = pdhv_pkg::HIST_FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pdhv_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  pdhv_pkg::qent_t  q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // [11:0] dac_code, [15:12] zero
    output logic             m_tuser    // filter_clipped
);
    import pdhv_pkg::*;

    // Feedforward sum is 34 bits before scaling, feedback terms are 44 bits each.
    localparam int FF_W  = 34 + HIST_FRAC_BITS;
    localparam int FB_W  = 46;
    localparam int ACC_W = ((FF_W > FB_W) ? FF_W : FB_W) + 1;
    localparam logic [ACC_W-1:0]   COEF_MASK = (ACC_W'(1) << COEF_FRAC_BITS) - 1'b1;
    localparam logic [YHIST_W-1:0] HIST_MASK = (YHIST_W'(1) << HIST_FRAC_BITS) - 1'b1;
    localparam logic [GAIN_W-1:0]  UNITY     = GAIN_W'(256);

    // Filter history.
    logic signed [CENTER_W-1:0] x1_reg, x2_reg;
    logic signed [YHIST_W-1:0]  y1_reg, y2_reg;
    logic signed [CENTER_W-1:0] x1_eff, x2_eff;
    logic signed [YHIST_W-1:0]  y1_eff, y2_eff;

    // Filter stage.
    logic                       a_valid_reg;
    logic signed [CENTER_W-1:0] a_x_reg;
    logic signed [YHIST_W-1:0]  a_y_reg;
    logic                       a_filt_reg;
    logic                       a_ready;

    logic signed [31:0]         p_b0x, p_b1x1, p_b0x2;
    logic signed [43:0]         p_a1y1, p_a2y2;
    logic signed [33:0]         ff_sum;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_tr;
    logic                       acc_ovf;
    logic signed [YHIST_W-1:0]  y_new;

    // Output stage.
    logic                       m_valid_reg;
    logic [DAC_W-1:0]           m_dac_reg;
    logic                       m_clip_reg;
    logic                       out_ready;
    logic signed [YHIST_W-1:0]  c_tr;
    logic                       c_ovf;
    logic signed [CENTER_W-1:0] c_val;
    logic                       c_clip;
    logic [GAIN_W-1:0]          gain_eff;
    logic signed [21:0]         vol_prod;
    logic signed [21:0]         vol_shift;
    logic [DAC_W-1:0]           dac_next;

    // Each stage moves when the one after it is empty or emptying.
    assign out_ready = !m_valid_reg || m_tready;
    assign a_ready   = !a_valid_reg || out_ready;
    assign q_pop     = q_valid && a_ready;

    // A stream start reads the history as cleared.
    assign x1_eff = q_data.start ? '0 : x1_reg;
    assign x2_eff = q_data.start ? '0 : x2_reg;
    assign y1_eff = q_data.start ? '0 : y1_reg;
    assign y2_eff = q_data.start ? '0 : y2_reg;

    // Five parallel products and the accumulator.
    assign p_b0x  = cfg.coef_b0 * q_data.x;
    assign p_b1x1 = cfg.coef_b1 * x1_eff;
    assign p_b0x2 = cfg.coef_b0 * x2_eff;
    assign p_a1y1 = cfg.coef_a1 * y1_eff;
    assign p_a2y2 = cfg.coef_a2 * y2_eff;
    assign ff_sum = 34'(p_b0x) + 34'(p_b1x1) + 34'(p_b0x2);
    assign acc    = (ACC_W'(ff_sum) <<< HIST_FRAC_BITS) - ACC_W'(p_a1y1) - ACC_W'(p_a2y2);

    // Truncate toward zero, then saturate to the history width.
    assign acc_tr  = (acc + (acc[ACC_W-1] ? signed'(COEF_MASK) : ACC_W'(0)))
                     >>> COEF_FRAC_BITS;
    assign acc_ovf = (acc_tr[ACC_W-1:YHIST_W-1] != '0) && (acc_tr[ACC_W-1:YHIST_W-1] != '1);

    always_comb begin
        if (acc_ovf) begin
            y_new = acc_tr[ACC_W-1] ? {1'b1, {(YHIST_W-1){1'b0}}} : {1'b0, {(YHIST_W-1){1'b1}}};
        end else begin
            y_new = acc_tr[YHIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (q_pop) begin
            if (cfg.filter_enable) begin
                x1_reg <= q_data.x;
                x2_reg <= x1_eff;
                y1_reg <= y_new;
                y2_reg <= y1_eff;
            end else begin
                x1_reg <= x1_eff;
                x2_reg <= x2_eff;
                y1_reg <= y1_eff;
                y2_reg <= y2_eff;
            end
        end
    end

    // Filter stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_x_reg    <= q_data.x;
            a_y_reg    <= y_new;
            a_filt_reg <= cfg.filter_enable;
        end
    end

    // Scale the filter output down to a sample, truncating toward zero, and clamp.
    assign c_tr  = (a_y_reg + (a_y_reg[YHIST_W-1] ? signed'(HIST_MASK) : YHIST_W'(0)))
                   >>> HIST_FRAC_BITS;
    assign c_ovf = (c_tr[YHIST_W-1:CENTER_W-1] != '0) && (c_tr[YHIST_W-1:CENTER_W-1] != '1);

    always_comb begin
        c_val  = a_x_reg;
        c_clip = 1'b0;
        if (a_filt_reg) begin
            c_clip = c_ovf;
            if (c_ovf) begin
                c_val = c_tr[YHIST_W-1] ? {1'b1, {(CENTER_W-1){1'b0}}}
                                        : {1'b0, {(CENTER_W-1){1'b1}}};
            end else begin
                c_val = c_tr[CENTER_W-1:0];
            end
        end
    end

    // Volume: gain above unity acts as unity; floor shift, then offset to midscale.
    assign gain_eff  = cfg.volume_gain[GAIN_W-1] ? UNITY : cfg.volume_gain;
    assign vol_prod  = c_val * signed'({1'b0, gain_eff});
    assign vol_shift = vol_prod >>> 8;
    assign dac_next  = vol_shift[DAC_W-1:0] + {1'b1, {(DAC_W-1){1'b0}}};

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && a_valid_reg) begin
            m_dac_reg  <= dac_next;
            m_clip_reg <= c_clip;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_dac_reg};
    assign m_tuser  = m_clip_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import pdhv_pkg::*;

    localparam int PIPE_LAT       = 3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_FRAMES   = 75;
    localparam int RANDOM_PHASES  = 6;

    // Highpass biquad around 100 Hz at 44.1 kHz, Q3.16.
    localparam int HP_B0 = 64880;
    localparam int HP_B1 = -129760;
    localparam int HP_A1 = -129749;
    localparam int HP_A2 = 64235;

    // Expected output of one frame.
    typedef struct packed {
        logic [DAC_W-1:0] dac_code;
        logic             filter_clipped;
    } dac_result_t;

    // Scoreboard: carries its own copy of the configuration and the filter history,
    // predicts the DAC code of each accepted frame and checks results in order.
    class dac_scoreboard;
        bit          wide_samples;
        bit          two_channels;
        bit          hp_on;
        longint      b0, b1, a1, a2;
        int unsigned gain_q8;
        longint      x_d1, x_d2, y_d1, y_d2;
        dac_result_t expected_q[$];
        int          mismatches;
        int          frames;
        int          checked;

        function new();
            wide_samples = 1'b1;
            two_channels = 1'b0;
            hp_on        = 1'b0;
            b0 = 0; b1 = 0; a1 = 0; a2 = 0;
            gain_q8      = 165;
            x_d1 = 0; x_d2 = 0; y_d1 = 0; y_d2 = 0;
            mismatches   = 0;
            frames       = 0;
            checked      = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            logic signed [COEF_W-1:0] cv;
            cv = v[COEF_W-1:0];
            case (idx)
                CFG_SAMPLE_WIDTH:  wide_samples = v[0];
                CFG_STEREO:        two_channels = v[0];
                CFG_FILTER_ENABLE: hp_on = v[0];
                CFG_COEF_B0:       b0 = cv;
                CFG_COEF_B1:       b1 = cv;
                CFG_COEF_A1:       a1 = cv;
                CFG_COEF_A2:       a2 = cv;
                CFG_VOLUME_GAIN:   gain_q8 = v[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Division by a power of two, rounded toward zero.
        function longint trunc_div(longint v, int sh);
            return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
        endfunction

        function void note_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic st);
            logic signed [SAMPLE_W-1:0] ls, rs;
            longint      s, xc, acc, y, c;
            longint      ymax;
            bit          clip;
            int unsigned g;
            dac_result_t res;
            ymax = (64'sd1 <<< (YHIST_W - 1)) - 1;
            clip = 1'b0;
            ls = l;
            rs = r;
            if (st) begin
                x_d1 = 0; x_d2 = 0; y_d1 = 0; y_d2 = 0;
            end
            // Decode the frame to a centered 12-bit value.
            if (!wide_samples) begin
                s = longint'(l[7:0]);
                if (two_channels) s = (s + longint'(r[7:0])) >>> 1;
                xc = s * 16 - 2048;
            end else begin
                s = ls;
                if (two_channels) s = (s + longint'(rs)) >>> 1;
                xc = s >>> 4;
            end
            // Biquad with saturated output history, or bypass.
            if (hp_on) begin
                acc = ((b0 * xc + b1 * x_d1 + b0 * x_d2) <<< HIST_FRAC_BITS_DEF)
                      - a1 * y_d1 - a2 * y_d2;
                y = trunc_div(acc, COEF_FRAC_BITS_DEF);
                if (y > ymax) y = ymax;
                if (y < -ymax - 1) y = -ymax - 1;
                x_d2 = x_d1;
                x_d1 = xc;
                y_d2 = y_d1;
                y_d1 = y;
                c = trunc_div(y, HIST_FRAC_BITS_DEF);
                if (c > 2047) begin
                    c = 2047;
                    clip = 1'b1;
                end
                if (c < -2048) begin
                    c = -2048;
                    clip = 1'b1;
                end
            end else begin
                c = xc;
            end
            // Volume, capped at unity, then offset to the DAC midpoint.
            g = (gain_q8 > 256) ? 256 : gain_q8;
            c = 2048 + ((c * longint'(g)) >>> 8);
            res.dac_code       = c[DAC_W-1:0];
            res.filter_clipped = clip;
            expected_q.push_back(res);
            frames++;
        endfunction

        function void check_output(logic [DAC_W-1:0] dac, logic clip);
            dac_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result: dac_code %0d, filter_clipped %0d", dac, clip);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (dac !== exp_r.dac_code) begin
                $error("dac_code mismatch: expected %0d, actual %0d", exp_r.dac_code, dac);
                mismatches++;
            end
            if (clip !== exp_r.filter_clipped) begin
                $error("filter_clipped mismatch: expected %0d, actual %0d",
                       exp_r.filter_clipped, clip);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // [15:0] left_sample, [31:16] right_sample
    logic                  s_tuser;   // stream_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // [11:0] dac_code, [15:12] zero
    logic                  m_tuser;   // filter_clipped
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    dac_scoreboard sb;
    int            src_idle_pct;
    int            sink_stall_pct;
    int            hold_left;
    int            quiet_cycles;
    int            cfg_sets;

    pcm_to_dac_highpass_volume dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_output(m_tdata[DAC_W-1:0], m_tuser);
        end
    end

    // Watchdog on cycles without any transaction.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Geometric number of idle cycles for the given idle percentage.
    function automatic int pick_gap(int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct) n++;
        return n;
    endfunction

    // Random sample word: extremes, small values around zero, or anything.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return SAMPLE_W'($urandom_range(63) - 32);
            default: return SAMPLE_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= v;
        sb.set_reg(idx, v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic program_all(bit sw, bit st, bit fe, int c_b0, int c_b1, int c_a1,
                               int c_a2, int gain);
        cfg_write(CFG_SAMPLE_WIDTH, CFG_DATA_W'(sw));
        cfg_write(CFG_STEREO, CFG_DATA_W'(st));
        cfg_write(CFG_FILTER_ENABLE, CFG_DATA_W'(fe));
        cfg_write(CFG_COEF_B0, CFG_DATA_W'(c_b0));
        cfg_write(CFG_COEF_B1, CFG_DATA_W'(c_b1));
        cfg_write(CFG_COEF_A1, CFG_DATA_W'(c_a1));
        cfg_write(CFG_COEF_A2, CFG_DATA_W'(c_a2));
        cfg_write(CFG_VOLUME_GAIN, CFG_DATA_W'(gain));
        cfg_sets++;
    endtask

    // Offer one frame after a random gap and wait for its transaction.
    task automatic send_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic st);
        int gap;
        gap = pick_gap(src_idle_pct);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        s_tuser  <= st;
        do @(posedge aclk); while (!s_tready);
        sb.note_frame(l, r, st);
    endtask

    // Stop offering and wait until every expected result has been checked.
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    // Main sequence: reset, directed frames, then randomized phases.
    initial begin
        int mode;
        int c_b0, c_b1, c_a1, c_a2, gain;
        int csel;
        sb             = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        cfg_sets       = 0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wr_data    = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset configuration: 16-bit mono, bypass, default volume.
        send_frame(16'h0000, 16'h1234, 1'b1);
        send_frame(16'h7FFF, 16'h0000, 1'b0);
        send_frame(16'h8000, 16'hFFFF, 1'b0);
        send_frame(16'hFFFF, 16'h8000, 1'b0);
        send_frame(16'h0010, 16'h7FFF, 1'b0);
        send_frame(16'hFFF0, 16'h5A5A, 1'b0);
        drain_block();

        // 8-bit stereo at unity gain; the high bytes must be ignored.
        program_all(1'b0, 1'b1, 1'b0, 0, 0, 0, 0, 256);
        send_frame(16'hA500, 16'h5A00, 1'b0);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0);
        send_frame(16'h00FF, 16'hFF00, 1'b0);
        send_frame(16'h0080, 16'h007F, 1'b0);
        drain_block();

        // 16-bit stereo averaging with zero volume.
        program_all(1'b1, 1'b1, 1'b0, 0, 0, 0, 0, 0);
        send_frame(16'h7FFF, 16'h7FFF, 1'b0);
        send_frame(16'h8000, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b0);
        drain_block();

        // Highpass with a gain above unity, restarted mid-stream.
        program_all(1'b1, 1'b0, 1'b1, HP_B0, HP_B1, HP_A1, HP_A2, 300);
        send_frame(16'h7FFF, 16'h0000, 1'b1);
        send_frame(16'h7FFF, 16'h0000, 1'b0);
        send_frame(16'h8000, 16'h0000, 1'b0);
        send_frame(16'h0000, 16'h0000, 1'b0);
        send_frame(16'h1234, 16'h0000, 1'b1);
        drain_block();

        // Extreme coefficients drive the history into saturation and the clamp.
        program_all(1'b1, 1'b0, 1'b1, 524287, -524288, -524288, 524287, 511);
        send_frame(16'h7FFF, 16'h0000, 1'b1);
        send_frame(16'h8000, 16'h0000, 1'b0);
        send_frame(16'h7FFF, 16'h0000, 1'b0);
        send_frame(16'h8000, 16'h0000, 1'b0);
        drain_block();

        // Random phases, each with its own settings and idle pattern.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = p % 4;
            src_idle_pct   = (mode == 1) ? 78 : (mode == 3) ? 21 : 0;
            sink_stall_pct = (mode == 2) ? 78 : (mode == 3) ? 21 : 0;
            csel = $urandom_range(2);
            if (csel == 0) begin
                c_b0 = HP_B0; c_b1 = HP_B1; c_a1 = HP_A1; c_a2 = HP_A2;
            end else if (csel == 1) begin
                c_b0 = $urandom_range(20'hFFFFF);
                c_b1 = $urandom_range(20'hFFFFF);
                c_a1 = $urandom_range(20'hFFFFF);
                c_a2 = $urandom_range(20'hFFFFF);
            end else begin
                c_b0 = HP_B0 + $urandom_range(2000) - 1000;
                c_b1 = HP_B1 + $urandom_range(2000) - 1000;
                c_a1 = HP_A1 + $urandom_range(2000) - 1000;
                c_a2 = HP_A2 + $urandom_range(2000) - 1000;
            end
            case ($urandom_range(2))
                0:       gain = 256;
                1:       gain = $urandom_range(256);
                default: gain = $urandom_range(511);
            endcase
            program_all(bit'($urandom_range(1)), bit'($urandom_range(1)),
                        bit'($urandom_range(3) != 0), c_b0, c_b1, c_a1, c_a2, gain);
            for (int i = 0; i < PHASE_FRAMES; i++) begin
                // One long receiver hold-off so the input side backs up.
                if (p == 0 && i == 10) hold_left = HOLD_CYCLES;
                send_frame(pick_sample(), pick_sample(), (i == 0) || ($urandom_range(39) == 0));
            end
            drain_block();
        end

        $display("tb_top: %0d frames under %0d register settings, %0d results checked",
                 sb.frames, cfg_sets + 1, sb.checked);
        $display("tb_top: 8/16-bit, mono/stereo, bypass/highpass, clamp, gain 0..511, hold-off");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
